// ===== rtl/bcmet_pkg.sv =====
package bcmet_pkg;

  localparam int COLOR_W     = 8;
  localparam int ERR_W       = 16;
  localparam int SIDE_REG_W  = 11;
  localparam int THR_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int DEF_MAX_SIDE = 1024;

  localparam int MEAN_STEPS  = COLOR_W;
  localparam int ERR_STEPS   = ERR_W;
  localparam int STEP_W      = $clog2(ERR_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIDE      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_THRESHOLD = CFG_IDX_W'(1);

  typedef struct packed {
    logic accum;
    logic prep;
    logic mean_step;
    logic mul1;
    logic mul2;
    logic dev;
    logic err_init;
    logic err_step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic block_last;
  } status_t;

endpackage

// ===== rtl/bcmet_pix_if.sv =====
interface bcmet_pix_if;
  import bcmet_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ===== rtl/bcmet_res_if.sv =====
interface bcmet_res_if;
  import bcmet_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] mean_red;
  logic [COLOR_W-1:0] mean_green;
  logic [COLOR_W-1:0] mean_blue;
  logic [ERR_W-1:0]   mean_error;
  logic               needs_split;

  modport source (output valid, output mean_red, output mean_green, output mean_blue,
                  output mean_error, output needs_split, input ready);
  modport sink (input valid, input mean_red, input mean_green, input mean_blue,
                input mean_error, input needs_split, output ready);
endinterface

// ===== rtl/bcmet_cfg_if.sv =====
interface bcmet_cfg_if;
  import bcmet_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/bcmet_ctrl.sv =====
module bcmet_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bcmet_pkg::status_t status,
  output bcmet_pkg::cmd_t   cmd
);
  import bcmet_pkg::*;

  typedef enum logic [3:0] {
    S_ACCUM,
    S_PREP,
    S_MEAN,
    S_MUL1,
    S_MUL2,
    S_DEV,
    S_EINIT,
    S_EDIV,
    S_LOAD
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;
  logic              load_ok;

  assign in_ready = (state == S_ACCUM);
  assign load_ok  = (state == S_LOAD) && (!out_valid || out_ready);

  always_comb begin
    cmd           = '0;
    cmd.accum     = in_ready && in_valid;
    cmd.prep      = (state == S_PREP);
    cmd.mean_step = (state == S_MEAN);
    cmd.mul1      = (state == S_MUL1);
    cmd.mul2      = (state == S_MUL2);
    cmd.dev       = (state == S_DEV);
    cmd.err_init  = (state == S_EINIT);
    cmd.err_step  = (state == S_EDIV);
    cmd.load      = load_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_ACCUM;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_ok) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_ACCUM: begin
          if (in_valid && status.block_last) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          step  <= '0;
          state <= S_MEAN;
        end
        S_MEAN: begin
          step <= step + 1'b1;
          if (step == STEP_W'(MEAN_STEPS - 1)) begin
            state <= S_MUL1;
          end
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_DEV;
        S_DEV:  state <= S_EINIT;
        S_EINIT: begin
          step  <= '0;
          state <= S_EDIV;
        end
        S_EDIV: begin
          step <= step + 1'b1;
          if (step == STEP_W'(ERR_STEPS - 1)) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (load_ok) begin
            state <= S_ACCUM;
          end
        end
        default: state <= S_ACCUM;
      endcase
    end
  end

`ifndef SYNTH
  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_LOAD))
    else $error("result became valid outside the load state");

  a_mean_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MEAN) |-> (step < STEP_W'(MEAN_STEPS)))
    else $error("mean division ran past its step count");

  a_no_pixel_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_ACCUM) |-> !cmd.accum)
    else $error("pixel accumulated while a block result is being formed");
`endif
endmodule

// ===== rtl/bcmet_dp.sv =====
module bcmet_dp #(
  parameter int MAX_SIDE = bcmet_pkg::DEF_MAX_SIDE
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bcmet_pkg::cmd_t                     cmd,
  output bcmet_pkg::status_t                  status,
  input  logic [bcmet_pkg::COLOR_W-1:0]       red,
  input  logic [bcmet_pkg::COLOR_W-1:0]       green,
  input  logic [bcmet_pkg::COLOR_W-1:0]       blue,
  input  logic                                cfg_we,
  input  logic [bcmet_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bcmet_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic [bcmet_pkg::COLOR_W-1:0]       mean_red,
  output logic [bcmet_pkg::COLOR_W-1:0]       mean_green,
  output logic [bcmet_pkg::COLOR_W-1:0]       mean_blue,
  output logic [bcmet_pkg::ERR_W-1:0]         mean_error,
  output logic                                needs_split
);
  import bcmet_pkg::*;

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int CNT_W  = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int SUM_W  = CNT_W + 2 * COLOR_W - COLOR_W;
  localparam int SQ_W   = CNT_W + 2 * COLOR_W;
  localparam int PSQ_W  = 2 * COLOR_W;
  localparam int V_W    = SUM_W + 1 + COLOR_W;
  localparam int DEV_W  = SQ_W + 2;

  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   side_sq;
  logic [THR_W-1:0]   thr;
  logic [SUM_W-1:0]   sum [3];
  logic [SQ_W-1:0]    sq [3];
  logic [SUM_W-1:0]   rem [3];
  logic [SUM_W-1:0]   dsh;
  logic [COLOR_W-1:0] mean [3];
  logic [SUM_W-1:0]   tnm [3];
  logic [V_W-1:0]     v [3];
  logic [DEV_W-1:0]   dev;
  logic [DEV_W-1:0]   erem;
  logic [DEV_W-1:0]   edsh;
  logic [ERR_W-1:0]   err;

  logic [COLOR_W-1:0] pix [3];
  logic [SIDE_W-1:0]  eff_side;
  logic [SIDE_REG_W-1:0] side_in;
  logic [CNT_W+1:0]   n3;
  logic [SUM_W:0]     u [3];
  logic [DEV_W-1:0]   dev_next;

  assign pix[0] = red;
  assign pix[1] = green;
  assign pix[2] = blue;

  assign status.block_last = ({1'b0, cnt} + 1'b1) >= {1'b0, side_sq};

  assign side_in = cfg_data[SIDE_REG_W-1:0];

  always_comb begin
    if (side_in == '0) begin
      eff_side = SIDE_W'(1);
    end else if (32'(side_in) > 32'(MAX_SIDE)) begin
      eff_side = SIDE_W'(MAX_SIDE);
    end else begin
      eff_side = SIDE_W'(side_in);
    end
  end

  assign n3 = {cnt, 1'b0} + (CNT_W + 2)'(cnt);

  always_comb begin
    dev_next = '0;
    for (int c = 0; c < 3; c++) begin
      u[c]     = {sum[c], 1'b0} - (SUM_W + 1)'(tnm[c]);
      dev_next = dev_next + DEV_W'(sq[c]) - DEV_W'(v[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_sq <= CNT_W'(1);
      thr     <= '0;
      cnt     <= '0;
      for (int c = 0; c < 3; c++) begin
        sum[c] <= '0;
        sq[c]  <= '0;
      end
    end else begin
      if (cfg_we && cfg_index == CFG_BLOCK_SIDE) begin
        side_sq <= CNT_W'(eff_side) * CNT_W'(eff_side);
      end
      if (cfg_we && cfg_index == CFG_ERROR_THRESHOLD) begin
        thr <= cfg_data[THR_W-1:0];
      end
      if (cmd.err_init) begin
        cnt <= '0;
        for (int c = 0; c < 3; c++) begin
          sum[c] <= '0;
          sq[c]  <= '0;
        end
      end else if (cmd.accum) begin
        cnt <= cnt + 1'b1;
        for (int c = 0; c < 3; c++) begin
          sum[c] <= sum[c] + SUM_W'(pix[c]);
          sq[c]  <= sq[c] + SQ_W'(PSQ_W'(pix[c]) * PSQ_W'(pix[c]));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      dsh <= SUM_W'(cnt) << (MEAN_STEPS - 1);
      for (int c = 0; c < 3; c++) begin
        rem[c]  <= sum[c];
        mean[c] <= '0;
      end
    end else if (cmd.mean_step) begin
      dsh <= dsh >> 1;
      for (int c = 0; c < 3; c++) begin
        if (rem[c] >= dsh) begin
          rem[c]  <= rem[c] - dsh;
          mean[c] <= {mean[c][COLOR_W-2:0], 1'b1};
        end else begin
          mean[c] <= {mean[c][COLOR_W-2:0], 1'b0};
        end
      end
    end
    if (cmd.mul1) begin
      for (int c = 0; c < 3; c++) begin
        tnm[c] <= SUM_W'(cnt) * SUM_W'(mean[c]);
      end
    end
    if (cmd.mul2) begin
      for (int c = 0; c < 3; c++) begin
        v[c] <= V_W'(u[c]) * V_W'(mean[c]);
      end
    end
    if (cmd.dev) begin
      dev <= dev_next;
    end
    if (cmd.err_init) begin
      erem <= dev;
      edsh <= DEV_W'(n3) << (ERR_STEPS - 1);
      err  <= '0;
    end else if (cmd.err_step) begin
      edsh <= edsh >> 1;
      if (erem >= edsh) begin
        erem <= erem - edsh;
        err  <= {err[ERR_W-2:0], 1'b1};
      end else begin
        err  <= {err[ERR_W-2:0], 1'b0};
      end
    end
    if (cmd.load) begin
      mean_red    <= mean[0];
      mean_green  <= mean[1];
      mean_blue   <= mean[2];
      mean_error  <= err;
      needs_split <= err > thr;
    end
  end

`ifndef SYNTH
  a_mean_remainder: assert property (@(posedge clk) disable iff (rst)
    cmd.mul1 |-> (rem[0] < SUM_W'(cnt) && rem[1] < SUM_W'(cnt) && rem[2] < SUM_W'(cnt)))
    else $error("channel mean division left a remainder not below the pixel count");

  a_dev_non_negative: assert property (@(posedge clk) disable iff (rst)
    cmd.dev |-> (DEV_W'(v[0]) <= DEV_W'(sq[0]) && DEV_W'(v[1]) <= DEV_W'(sq[1])
                 && DEV_W'(v[2]) <= DEV_W'(sq[2])))
    else $error("squared deviation of a channel went negative");

  a_error_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (err <= ERR_W'((2 ** COLOR_W - 1) ** 2)))
    else $error("block error above the largest squared colour step");
`endif
endmodule

// ===== rtl/block_color_mean_error_test_top.sv =====
// Colour mean and mean squared error test over one square block of RGB pixels.
// The pix channel carries one pixel per transfer in block row order; the res
// channel carries one result per block; cfg writes block_side (index 0) and
// error_threshold (index 1) and is always ready.
// A pixel is taken in each cycle while the block is accumulating. The transfer
// of the last pixel of a block (the count reaching the side squared) starts the
// result phase: a prep step, channel mean division, multiply and deviation
// sum, error division and a load. No pixel is taken during that phase.
// The result sits in an output register until the receiver takes it; the next
// block accumulates meanwhile. If the receiver still stalls when the following
// result is ready, the block holds that result and takes no pixel until the
// output register frees.
// Reset clears the accumulators, sets the side to 1 and the threshold to 0 and
// empties the output register.
module block_color_mean_error_test_top #(
  parameter int MAX_SIDE = bcmet_pkg::DEF_MAX_SIDE
) (
  input logic          clk,
  input logic          rst,
  bcmet_pix_if.sink    pix,
  bcmet_res_if.source  res,
  bcmet_cfg_if.sink    cfg
);
  import bcmet_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg.ready = 1'b1;

  bcmet_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix.valid),
    .in_ready  (pix.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .status    (status),
    .cmd       (cmd)
  );

  bcmet_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .red         (pix.red),
    .green       (pix.green),
    .blue        (pix.blue),
    .cfg_we      (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .mean_red    (res.mean_red),
    .mean_green  (res.mean_green),
    .mean_blue   (res.mean_blue),
    .mean_error  (res.mean_error),
    .needs_split (res.needs_split)
  );
endmodule
